### hdl/cscb_pkg.sv
// Shared types and constants for the CAN signal bit-field codec.
package cscb_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FRAC_BITS   = 16;

    localparam int FRAME_BITS_INT = (FRAME_BYTES * 8 > 64) ? 64 : FRAME_BYTES * 8;
    localparam logic [7:0] FRAME_BITS = 8'(FRAME_BITS_INT);

    localparam int RND_SHIFT = (2 * FRAC_BITS > 64) ? 64 : 2 * FRAC_BITS;
    localparam logic [95:0] ROUND_HALF = (RND_SHIFT == 0) ? 96'd0 : (96'd1 << (RND_SHIFT - 1));

    localparam int APB_ADDR_W = 6;
    localparam int APB_DATA_W = 64;

    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_DECODE = 1'b1;

    typedef enum logic [2:0] {
        REG_START_POSITION   = 3'd0,
        REG_FIELD_LENGTH     = 3'd1,
        REG_MOTOROLA_ORDER   = 3'd2,
        REG_SIGNED_FIELD     = 3'd3,
        REG_SCALE_FACTOR     = 3'd4,
        REG_SCALE_RECIPROCAL = 3'd5,
        REG_SCALE_OFFSET     = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [5:0]         start_position;
        logic [6:0]         field_length;
        logic               motorola_order;
        logic               signed_field;
        logic [31:0]        scale_factor;
        logic [31:0]        scale_reciprocal;
        logic signed [63:0] scale_offset;
    } cscb_cfg_t;

endpackage

### hdl/cscb_regs.sv
// APB configuration register file of the CAN signal codec.
module cscb_regs
    import cscb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cscb_cfg_t             cfg
);

    cscb_cfg_t cfg_reg;
    cscb_cfg_t cfg_next;
    reg_idx_t  idx;
    logic      wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_START_POSITION:   cfg_next.start_position   = pwdata[5:0];
                REG_FIELD_LENGTH:     cfg_next.field_length     = pwdata[6:0];
                REG_MOTOROLA_ORDER:   cfg_next.motorola_order   = pwdata[0];
                REG_SIGNED_FIELD:     cfg_next.signed_field     = pwdata[0];
                REG_SCALE_FACTOR:     cfg_next.scale_factor     = pwdata[31:0];
                REG_SCALE_RECIPROCAL: cfg_next.scale_reciprocal = pwdata[31:0];
                REG_SCALE_OFFSET:     cfg_next.scale_offset     = pwdata;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START_POSITION:   prdata = {58'd0, cfg_reg.start_position};
            REG_FIELD_LENGTH:     prdata = {57'd0, cfg_reg.field_length};
            REG_MOTOROLA_ORDER:   prdata = {63'd0, cfg_reg.motorola_order};
            REG_SIGNED_FIELD:     prdata = {63'd0, cfg_reg.signed_field};
            REG_SCALE_FACTOR:     prdata = {32'd0, cfg_reg.scale_factor};
            REG_SCALE_RECIPROCAL: prdata = {32'd0, cfg_reg.scale_reciprocal};
            REG_SCALE_OFFSET:     prdata = cfg_reg.scale_offset;
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_position   <= 6'd0;
            cfg_reg.field_length     <= 7'd8;
            cfg_reg.motorola_order   <= 1'b0;
            cfg_reg.signed_field     <= 1'b0;
            cfg_reg.scale_factor     <= 32'd65536;
            cfg_reg.scale_reciprocal <= 32'd65536;
            cfg_reg.scale_offset     <= 64'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### hdl/cscb_field_extract.sv
// Gathers the configured signal field out of a frame, with sign extension.
module cscb_field_extract
    import cscb_pkg::*;
(
    input  cscb_cfg_t   cfg,
    input  logic [63:0] frame,
    output logic [63:0] raw
);

    logic [6:0]  len;
    logic        len_ok;
    logic [5:0]  start_flip;
    logic [63:0] gath;
    logic        ext_bit;

    always_comb
    begin
        len        = cfg.field_length;
        len_ok     = (len != 7'd0) && (len <= 7'd64);
        start_flip = cfg.start_position ^ 6'd7;
        for (int rb = 0; rb < 64; rb++)
        begin : g_gather
            logic [7:0] pos;
            // Motorola: byte-flipped numbering makes the walk a plain count
            pos = cfg.motorola_order
                ? ((8'(start_flip) + 8'(len) - 8'd1 - 8'(rb)) ^ 8'd7)
                : (8'(cfg.start_position) + 8'(rb));
            gath[rb] = (len_ok && (8'(rb) < 8'(len)) && (pos < FRAME_BITS))
                     ? frame[pos[5:0]] : 1'b0;
        end
        ext_bit = cfg.signed_field & len_ok & gath[6'(len - 7'd1)];
        for (int rb = 0; rb < 64; rb++)
        begin
            raw[rb] = (8'(rb) < 8'(len)) ? gath[rb] : ext_bit;
        end
    end

endmodule

### hdl/cscb_field_insert.sv
// Merges a raw value into the configured signal field of a frame.
module cscb_field_insert
    import cscb_pkg::*;
(
    input  cscb_cfg_t   cfg,
    input  logic [63:0] frame_old,
    input  logic [63:0] raw,
    output logic [63:0] frame_new
);

    logic [6:0] len;
    logic       len_ok;
    logic [5:0] start_key;

    always_comb
    begin
        len       = cfg.field_length;
        len_ok    = (len != 7'd0) && (len <= 7'd64);
        start_key = cfg.motorola_order ? (cfg.start_position ^ 6'd7) : cfg.start_position;
        for (int p = 0; p < 64; p++)
        begin : g_scatter
            logic [5:0] pos_key;
            logic [7:0] walk_idx;
            logic [5:0] rb;
            logic       hit;
            pos_key  = cfg.motorola_order ? (6'(p) ^ 6'd7) : 6'(p);
            walk_idx = {2'b00, pos_key} - {2'b00, start_key};
            hit      = len_ok && !walk_idx[7] && (walk_idx < 8'(len)) && (8'(p) < FRAME_BITS);
            rb       = cfg.motorola_order ? 6'(len - 7'd1 - walk_idx[6:0]) : walk_idx[5:0];
            frame_new[p] = hit ? raw[rb] : frame_old[p];
        end
    end

endmodule

### hdl/can_signal_bitfield_codec.sv
// Top level of the CAN signal codec: config port, seven-stage datapath, frame store.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  item     | item_valid / item_ready   | func, phys_value, frame_in
//  result   | result_valid / result_ready | frame_out, phys_out
//  config   | APB psel/penable/pwrite   | paddr, pwdata, prdata
//
// One transaction per cycle unless result_ready stalls; stage 6 drives result_valid.
// The 64x32 scaling product is split into two 32x32 halves in stage 3.
// Each stage holds its transaction until the next stage frees up, so
// items keep entering while a result waits, until every stage is full.
// Reset clears all valids, the frame store and the config registers to their defaults.
module can_signal_bitfield_codec
    import cscb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  logic                  func,
    input  logic signed [63:0]    phys_value,
    input  logic [63:0]           frame_in,
    output logic                  result_valid,
    input  logic                  result_ready,
    output logic [63:0]           frame_out,
    output logic signed [63:0]    phys_out
);

    localparam logic [63:0] PHYS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] PHYS_MIN = 64'h8000_0000_0000_0000;

    cscb_cfg_t cfg;

    logic [6:0] stage_valid_reg;
    logic [6:0] stage_valid_next;
    logic [7:0] stage_ready;

    logic        s0_func_reg;
    logic [63:0] s0_phys_reg;
    logic [63:0] s0_frame_reg;

    logic [63:0] raw_dec;
    logic [64:0] diff;
    logic        s1_func_reg, s1_func_next;
    logic        s1_neg_reg, s1_neg_next;
    logic [63:0] s1_val_reg, s1_val_next;

    logic        s2_func_reg, s2_neg_reg;
    logic [63:0] s2_mag_reg, s2_mag_next;
    logic [31:0] s2_mult_reg, s2_mult_next;

    logic        s3_func_reg, s3_neg_reg;
    logic [63:0] s3_p0_reg, s3_p0_next;
    logic [63:0] s3_p1_reg, s3_p1_next;

    logic        s4_func_reg, s4_neg_reg;
    logic [95:0] s4_sum_reg, s4_sum_next;

    logic        s5_func_reg;
    logic [96:0] s5_res_reg, s5_res_next;
    logic [63:0] quot;
    logic [96:0] neg_op;

    logic [63:0] frame_merged;
    logic [63:0] frame_store_reg, frame_store_next;
    logic [97:0] total;
    logic        total_fits;
    logic [63:0] phys_out_reg, phys_out_next;
    logic        store_load;

    cscb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cscb_field_extract u_extract (
        .cfg   (cfg),
        .frame (s0_frame_reg),
        .raw   (raw_dec)
    );

    cscb_field_insert u_insert (
        .cfg       (cfg),
        .frame_old (frame_store_reg),
        .raw       (s5_res_reg[63:0]),
        .frame_new (frame_merged)
    );

    // handshake chain
    always_comb
    begin
        stage_ready[7] = result_ready;
        for (int k = 6; k >= 0; k--)
        begin
            stage_ready[k] = !stage_valid_reg[k] | stage_ready[k+1];
        end
        stage_valid_next[0] = stage_ready[0] ? item_valid : stage_valid_reg[0];
        for (int k = 1; k < 7; k++)
        begin
            stage_valid_next[k] = stage_ready[k] ? stage_valid_reg[k-1] : stage_valid_reg[k];
        end
    end

    assign item_ready   = stage_ready[0];
    assign result_valid = stage_valid_reg[6];
    assign frame_out    = frame_store_reg;
    assign phys_out     = phys_out_reg;

    // stage 1: offset removal or field gather
    always_comb
    begin
        diff         = {s0_phys_reg[63], s0_phys_reg} - {cfg.scale_offset[63], cfg.scale_offset};
        s1_func_next = s0_func_reg;
        if (s0_func_reg == FUNC_ENCODE)
        begin
            s1_neg_next = diff[64];
            s1_val_next = diff[63:0];
        end
        else
        begin
            s1_neg_next = cfg.signed_field & raw_dec[63];
            s1_val_next = raw_dec;
        end
    end

    // stage 2: magnitude and multiplier select
    assign s2_mag_next  = s1_neg_reg ? (~s1_val_reg + 64'd1) : s1_val_reg;
    assign s2_mult_next = (s1_func_reg == FUNC_DECODE) ? cfg.scale_factor : cfg.scale_reciprocal;

    // stage 3: partial products
    assign s3_p0_next = s2_mag_reg[31:0]  * s2_mult_reg;
    assign s3_p1_next = s2_mag_reg[63:32] * s2_mult_reg;

    // stage 4: product sum, rounding on encode
    assign s4_sum_next = {s3_p1_reg, 32'd0} + {32'd0, s3_p0_reg}
                       + ((s3_func_reg == FUNC_ENCODE) ? ROUND_HALF : 96'd0);

    // stage 5: shift on encode, then reapply sign
    always_comb
    begin
        quot        = 64'(s4_sum_reg >> RND_SHIFT);
        neg_op      = (s4_func_reg == FUNC_DECODE) ? {1'b0, s4_sum_reg} : {33'd0, quot};
        s5_res_next = s4_neg_reg ? (~neg_op + 97'd1) : neg_op;
    end

    // stage 6: frame merge or offset add with saturation
    always_comb
    begin
        total      = {s5_res_reg[96], s5_res_reg} + {{34{cfg.scale_offset[63]}}, cfg.scale_offset};
        total_fits = (&total[97:63]) | ~(|total[97:63]);
        if (s5_func_reg == FUNC_DECODE)
        begin
            phys_out_next = total_fits ? total[63:0] : (total[97] ? PHYS_MIN : PHYS_MAX);
        end
        else
        begin
            phys_out_next = 64'd0;
        end
        store_load       = stage_ready[6] & stage_valid_reg[5] & (s5_func_reg == FUNC_ENCODE);
        frame_store_next = store_load ? frame_merged : frame_store_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            frame_store_reg <= '0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            frame_store_reg <= frame_store_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_ready[0])
        begin
            s0_func_reg  <= func;
            s0_phys_reg  <= phys_value;
            s0_frame_reg <= frame_in;
        end
        if (stage_ready[1])
        begin
            s1_func_reg <= s1_func_next;
            s1_neg_reg  <= s1_neg_next;
            s1_val_reg  <= s1_val_next;
        end
        if (stage_ready[2])
        begin
            s2_func_reg <= s1_func_reg;
            s2_neg_reg  <= s1_neg_reg;
            s2_mag_reg  <= s2_mag_next;
            s2_mult_reg <= s2_mult_next;
        end
        if (stage_ready[3])
        begin
            s3_func_reg <= s2_func_reg;
            s3_neg_reg  <= s2_neg_reg;
            s3_p0_reg   <= s3_p0_next;
            s3_p1_reg   <= s3_p1_next;
        end
        if (stage_ready[4])
        begin
            s4_func_reg <= s3_func_reg;
            s4_neg_reg  <= s3_neg_reg;
            s4_sum_reg  <= s4_sum_next;
        end
        if (stage_ready[5])
        begin
            s5_func_reg <= s4_func_reg;
            s5_res_reg  <= s5_res_next;
        end
        if (stage_ready[6])
        begin
            phys_out_reg <= phys_out_next;
        end
    end

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> ((&stage_valid_reg) && !result_ready))
        else $error("item_ready low with a free pipeline stage");

    a_store_change: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(frame_store_reg) |->
            $past(stage_ready[6] && stage_valid_reg[5] && (s5_func_reg == FUNC_ENCODE)))
        else $error("frame store changed without an encode transaction");

    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(stage_valid_reg[5]))
        else $error("result appeared without a transaction in the last stage");

endmodule
